FILE: hw/rtl/bdascii_pkg.sv
package bdascii_pkg;

	// digit and character widths
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 6;

	// ascii code of '0', truncated to the character width
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// commands from controller to datapath
	typedef struct packed {
		logic load;   // take a new value, clear bcd
		logic shift;  // one double-dabble step
		logic drop;   // move to the next digit
	} bdascii_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic shift_last;  // current shift is the final one
		logic top_zero;    // leading digit is zero
		logic last_digit;  // leading digit is the least significant one
	} bdascii_sts_t;

endpackage

FILE: hw/rtl/bdascii_datapath.sv
module bdascii_datapath
	import bdascii_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [VALUE_BITS-1:0] value,
	input  bdascii_cmd_t          cmd,
	output bdascii_sts_t          sts,
	output logic [CHAR_W-1:0]     digit_char
);

	// decimal digits needed for the largest value
	localparam int NDIG   = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int BCD_W  = NDIG * DIGIT_W;
	localparam int SCNT_W = $clog2(VALUE_BITS + 1);
	localparam int DCNT_W = $clog2(NDIG + 1);

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [SCNT_W-1:0]     shift_cnt_q;
	logic [DCNT_W-1:0]     dig_cnt_q;
	logic [DIGIT_W-1:0]    top_digit;

	// add-3 correction on every digit before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// binary and bcd shift registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cmd.shift) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
		end else if (cmd.drop) begin
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	// shift and digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_cnt_q <= '0;
			dig_cnt_q   <= '0;
		end else if (cmd.load) begin
			shift_cnt_q <= SCNT_W'(VALUE_BITS);
			dig_cnt_q   <= DCNT_W'(NDIG);
		end else begin
			if (cmd.shift) begin
				shift_cnt_q <= shift_cnt_q - SCNT_W'(1);
			end
			if (cmd.drop) begin
				dig_cnt_q <= dig_cnt_q - DCNT_W'(1);
			end
		end
	end

	// status and character output
	assign top_digit      = bcd_q[BCD_W-1 -: DIGIT_W];
	assign sts.shift_last = (shift_cnt_q == SCNT_W'(1));
	assign sts.top_zero   = (top_digit == '0);
	assign sts.last_digit = (dig_cnt_q == DCNT_W'(1));
	assign digit_char     = {{(CHAR_W-DIGIT_W){1'b0}}, top_digit} + ASCII_ZERO;

endmodule

FILE: hw/rtl/bdascii_ctrl.sv
module bdascii_ctrl
	import bdascii_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  bdascii_sts_t sts,
	output bdascii_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				if (sts.shift_last) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// strip leading zeros, keep at least one digit
				if (sts.top_zero && !sts.last_digit) begin
					cmd.drop = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.last_digit) begin
						state_d = ST_IDLE;
					end else begin
						cmd.drop = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a new item starts a conversion on the next cycle
	a_load_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_CONV)
		else $error("load did not start conversion");

	// emitting ends only on the last digit
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_ready && !sts.last_digit |=> state_q == ST_EMIT)
		else $error("digit run ended early");

	// commands never overlap
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.shift, cmd.drop}))
		else $error("overlapping datapath commands");

endmodule

FILE: hw/rtl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter.
//
// Input channel: value with in_valid / in_ready. One unsigned number per item.
// Output channel: digit_char / last_digit with out_valid / out_ready. One item
// per decimal digit, most significant first, no leading zeros; zero gives a
// single '0'. last_digit marks the least significant digit of the run.
//
// Operation: after an item is taken the converter runs VALUE_BITS double-dabble
// shifts, then strips the leading zeros, then presents one digit per cycle
// while the receiver does not stall.
//
// One item is in flight at a time: in_ready is high only when the block is
// idle. A stalled receiver holds the current digit on the outputs until it is
// taken. Reset returns the block to idle and drops any item in progress.
module binary_to_decimal_ascii
	import bdascii_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CHAR_W-1:0]     digit_char,
	output logic                  last_digit
);

	bdascii_cmd_t cmd;
	bdascii_sts_t sts;

	// controller
	bdascii_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	bdascii_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.digit_char (digit_char)
	);

	assign last_digit = sts.last_digit;

	// characters are always decimal digits
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_char >= ASCII_ZERO && digit_char <= ASCII_ZERO + CHAR_W'(9))
		else $error("character out of digit range");

	// no new item while digits are still being sent
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken during output run");

	// the last digit ends the run
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_digit |=> !out_valid && in_ready)
		else $error("run continued after last digit");

endmodule

FILE: tb/sv/binary_to_decimal_ascii_test.sv
`timescale 1ns / 1ps

module binary_to_decimal_ascii_test;
	import bdascii_pkg::*;

	localparam int VB = 32;
	localparam int DRAIN_CYCLES = 60;
	localparam int NUM_RANDOM = 147;
	localparam int CALM_TAIL = 30;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_item_t;

	typedef struct {
		logic [VB-1:0] num;
		string         golden;  // empty: take the predictor
	} number_row_t;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic [VB-1:0] value;
	logic          out_valid;
	logic          out_ready;
	logic [CHAR_W-1:0] digit_char;
	logic          last_digit;

	digit_item_t digit_queue [$];
	int          fail_count;
	bit          idling;
	int          stall_left;

	number_row_t number_rows [23] = '{
		'{32'd0,          "0"},
		'{32'd1,          "1"},
		'{32'd9,          "9"},
		'{32'd10,         "10"},
		'{32'd99,         "99"},
		'{32'd100,        "100"},
		'{32'hFFFFFFFF,   "4294967295"},
		'{32'hFFFFFFFE,   "4294967294"},
		'{32'd1000000000, "1000000000"},
		'{32'd999999999,  "999999999"},
		'{32'h80000000,   "2147483648"},
		'{32'h7FFFFFFF,   "2147483647"},
		'{32'h55555555,   ""},
		'{32'hAAAAAAAA,   ""},
		'{32'd12345,      ""},
		'{32'd1234567890, ""},
		'{32'h0000FFFF,   ""},
		'{32'h00010000,   ""},
		'{32'd4000000000, ""},
		'{32'd3999999999, ""},
		'{32'd100000,     ""},
		'{32'd909090909,  ""},
		'{32'd10000000,   ""}
	};

	binary_to_decimal_ascii #(
		.VALUE_BITS(VB)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.digit_char(digit_char),
		.last_digit(last_digit)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	// decimal digits of a number, most significant first
	function automatic void predict_digits(input logic [VB-1:0] num);
		logic [VB-1:0] rest;
		logic [3:0]    rev [20];
		int            n;
		digit_item_t   d;
		rest = num;
		n = 0;
		do begin
			rev[n] = 4'(rest % 10);
			rest = rest / 10;
			n++;
		end while (rest != 0);
		for (int k = n - 1; k >= 0; k--) begin
			d.ch = CHAR_W'(rev[k]) + CHAR_W'(48);
			d.last = (k == 0);
			digit_queue.push_back(d);
		end
	endfunction

	// typed-in digit string as expected items
	function automatic void push_golden(input string golden);
		digit_item_t d;
		byte         b;
		for (int i = 0; i < golden.len(); i++) begin
			b = golden[i];
			d.ch = b[CHAR_W-1:0];
			d.last = (i == golden.len() - 1);
			digit_queue.push_back(d);
		end
	endfunction

	function automatic logic [VB-1:0] pow10(input int k);
		logic [VB-1:0] p;
		p = 1;
		for (int i = 0; i < k; i++)
			p = p * 10;
		return p;
	endfunction

	// random number, spread over digit counts and decimal boundaries
	function automatic logic [VB-1:0] pick_number();
		int n;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1, 2: begin
				n = $urandom_range(1, 10);
				if (n == 10)
					return $urandom_range(32'd1000000000, 32'hFFFFFFFF);
				else if (n == 1)
					return $urandom_range(0, 9);
				else
					return $urandom_range(pow10(n - 1), pow10(n) - 1);
			end
			default: begin
				n = $urandom_range(1, 9);
				return $urandom_range(0, 1) ? pow10(n) : pow10(n) - 1;
			end
		endcase
	endfunction

	// send one item; called at a falling edge, returns at a falling edge
	task automatic put_number(input logic [VB-1:0] num, input string golden);
		int gap;
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			value <= $urandom;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		value <= num;
		do @(posedge clk); while (!in_ready);
		if (golden.len() != 0)
			push_golden(golden);
		else
			predict_digits(num);
		@(negedge clk);
	endtask

	// receiver stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 3) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		digit_item_t d;
		if (arst_n && out_valid && out_ready) begin
			if (digit_queue.size() == 0) begin
				$error("unexpected item: digit_char %0d last_digit %0b", digit_char, last_digit);
				fail_count++;
			end else begin
				d = digit_queue.pop_front();
				if (digit_char !== d.ch) begin
					$error("digit_char: expected %0d, actual %0d", d.ch, digit_char);
					fail_count++;
				end
				if (last_digit !== d.last) begin
					$error("last_digit: expected %0b, actual %0b", d.last, last_digit);
					fail_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		fail_count = 0;
		stall_left = 0;
		idling = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (number_rows[i])
			put_number(number_rows[i].num, number_rows[i].golden);

		// hold off until every digit has come out
		in_valid <= 1'b0;
		while (digit_queue.size() != 0)
			@(negedge clk);

		// random part, quiet at the end
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == NUM_RANDOM - CALM_TAIL)
				idling = 1'b0;
			put_number(pick_number(), "");
		end
		in_valid <= 1'b0;

		// drain
		while (digit_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0 && digit_queue.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
